[src/dfa_pkg.sv]
package dfa_pkg;

   // Field widths
   localparam int EPOCH_W  = 32;
   localparam int OFFSET_W = 17;
   localparam int TEMP_W   = 16;
   localparam int PRECIP_W = 7;
   localparam int COND_W   = 10;
   localparam int DIST_W   = 16;

   // Local time arithmetic. A point's local time is biased by one day so it
   // never goes negative; day numbers are then off by one for every point
   // and for the current time alike, which leaves all comparisons intact.
   localparam int LOCAL_W = 33;
   localparam int DAY_W   = 17;
   localparam int SEC_W   = 17;
   localparam logic [LOCAL_W-1:0] DAY_BIAS = 33'd86400;

   // 86400 = 128 * 675: shift by 7, then multiply by a reciprocal of 675.
   localparam int SPLIT_SHIFT = 7;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 36;
   localparam int PROD_W      = LOCAL_W - SPLIT_SHIFT + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_675 = 27'd101806633;

   localparam logic [SEC_W-1:0]  SECONDS_PER_DAY = 17'd86400;
   localparam logic [SEC_W-1:0]  NOON_SECONDS    = 17'd43200;
   localparam logic [DIST_W-1:0] DIST_SENTINEL   = 16'hFFFF;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_EPOCH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEZONE_OFFSET = 2'd1;

   // Day selection
   localparam logic DAY_TODAY    = 1'b0;
   localparam logic DAY_TOMORROW = 1'b1;

   // Point data carried along the front pipeline
   typedef struct packed {
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic [PRECIP_W-1:0]      precip;
      logic [COND_W-1:0]        condition;
      logic                     last;
      logic                     known;
   } dfa_pay_type;

   // Classified point, as held in the queue
   typedef struct packed {
      dfa_pay_type         pay;
      logic                hit_today;
      logic                hit_tomorrow;
      logic [DIST_W-1:0]   noon_gap;
   } dfa_item_type;

   // Queue write side and queue head
   typedef struct packed {
      logic         valid;
      dfa_item_type item;
   } dfa_slot_type;

endpackage

[src/dfa_req_if.sv]
interface dfa_req_if;
   logic                valid;
   logic                ready;
   logic [31:0]         point_epoch;
   logic signed [15:0]  point_min_temp;
   logic signed [15:0]  point_max_temp;
   logic [6:0]          point_precip;
   logic [9:0]          point_condition;
   logic                last_point;

   modport source (
      output valid, point_epoch, point_min_temp, point_max_temp, point_precip,
             point_condition, last_point,
      input  ready
   );

   modport sink (
      input  valid, point_epoch, point_min_temp, point_max_temp, point_precip,
             point_condition, last_point,
      output ready
   );
endinterface

[src/dfa_rsp_if.sv]
interface dfa_rsp_if;
   logic                valid;
   logic                ready;
   logic                day_select;
   logic                day_valid;
   logic signed [15:0]  day_min_temp;
   logic signed [15:0]  day_max_temp;
   logic [6:0]          day_precip;
   logic [9:0]          day_condition;
   logic                any_valid;
   logic                run_last;

   modport source (
      output valid, day_select, day_valid, day_min_temp, day_max_temp, day_precip,
             day_condition, any_valid, run_last,
      input  ready
   );

   modport sink (
      input  valid, day_select, day_valid, day_min_temp, day_max_temp, day_precip,
             day_condition, any_valid, run_last,
      output ready
   );
endinterface

[src/dfa_front.sv]
module dfa_front #(
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dfa_req_if.sink                               req_chan,
   input  logic [dfa_pkg::EPOCH_W-1:0]           cur_epoch,
   input  logic signed [dfa_pkg::OFFSET_W-1:0]   tz_offset,
   input  logic                                  pop,
   output dfa_pkg::dfa_slot_type                 push
);
   import dfa_pkg::*;

   localparam int CREDIT_W = $clog2(DEPTH + 1);

   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                accept;

   // stage 1: local times
   logic [LOCAL_W-1:0]  local_pt, local_cur;
   logic                s1_valid_ff;
   dfa_pay_type         s1_pay_ff;
   logic                s1_later_ff;
   logic [LOCAL_W-1:0]  s1_upt_ff, s1_ucur_ff;

   // stage 2: day numbers
   logic [PROD_W-1:0]   prod_pt, prod_cur;
   logic                s2_valid_ff;
   dfa_pay_type         s2_pay_ff;
   logic                s2_later_ff;
   logic [DAY_W-1:0]    s2_qpt_ff, s2_qcur_ff;
   logic [SEC_W-1:0]    s2_ulow_ff;

   // stage 3: seconds into day, day match
   logic [SEC_W-1:0]    day_base, sec;
   logic                s3_valid_ff;
   dfa_pay_type         s3_pay_ff;
   logic                s3_hit_today_ff, s3_hit_tomorrow_ff;
   logic [SEC_W-1:0]    s3_sec_ff;
   logic [DIST_W-1:0]   noon_gap;

   // Count items from acceptance until they leave the queue
   assign req_chan.ready = credit_ff < CREDIT_W'(DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;
   assign credit_in      = credit_ff + CREDIT_W'(accept) - CREDIT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign local_pt  = {1'b0, req_chan.point_epoch}
                    + {{(LOCAL_W-OFFSET_W){tz_offset[OFFSET_W-1]}}, tz_offset}
                    + DAY_BIAS;
   assign local_cur = {1'b0, cur_epoch}
                    + {{(LOCAL_W-OFFSET_W){tz_offset[OFFSET_W-1]}}, tz_offset}
                    + DAY_BIAS;

   assign prod_pt  = PROD_W'(s1_upt_ff[LOCAL_W-1:SPLIT_SHIFT]) * PROD_W'(RECIP_675);
   assign prod_cur = PROD_W'(s1_ucur_ff[LOCAL_W-1:SPLIT_SHIFT]) * PROD_W'(RECIP_675);

   // sec is below one day, so the low bits of the difference are exact
   assign day_base = SEC_W'(s2_qpt_ff) * SECONDS_PER_DAY;
   assign sec      = s2_ulow_ff - day_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pay_ff.min_temp  <= req_chan.point_min_temp;
      s1_pay_ff.max_temp  <= req_chan.point_max_temp;
      s1_pay_ff.precip    <= req_chan.point_precip;
      s1_pay_ff.condition <= req_chan.point_condition;
      s1_pay_ff.last      <= req_chan.last_point;
      s1_pay_ff.known     <= cur_epoch != '0;
      s1_later_ff         <= req_chan.point_epoch >= cur_epoch;
      s1_upt_ff           <= local_pt;
      s1_ucur_ff          <= local_cur;

      s2_pay_ff   <= s1_pay_ff;
      s2_later_ff <= s1_later_ff;
      s2_qpt_ff   <= prod_pt[RECIP_SHIFT +: DAY_W];
      s2_qcur_ff  <= prod_cur[RECIP_SHIFT +: DAY_W];
      s2_ulow_ff  <= s1_upt_ff[SEC_W-1:0];

      s3_pay_ff          <= s2_pay_ff;
      s3_hit_today_ff    <= (s2_qpt_ff == s2_qcur_ff) && s2_later_ff;
      s3_hit_tomorrow_ff <= {1'b0, s2_qpt_ff} == ({1'b0, s2_qcur_ff} + (DAY_W+1)'(1));
      s3_sec_ff          <= sec;
   end

   assign noon_gap = (s3_sec_ff >= NOON_SECONDS) ? DIST_W'(s3_sec_ff - NOON_SECONDS)
                                                 : DIST_W'(NOON_SECONDS - s3_sec_ff);

   assign push.valid             = s3_valid_ff;
   assign push.item.pay          = s3_pay_ff;
   assign push.item.hit_today    = s3_hit_today_ff;
   assign push.item.hit_tomorrow = s3_hit_tomorrow_ff;
   assign push.item.noon_gap     = noon_gap;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(DEPTH))
      else $error("front credit count above queue depth");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted point did not enter the pipeline");

   a_empty_pipe: assert property (@(posedge clock) disable iff (reset)
      (credit_ff == '0) |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("point in flight without credit");
`endif

endmodule

[src/dfa_queue.sv]
module dfa_queue #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfa_pkg::dfa_slot_type push,
   input  logic                  pop,
   output dfa_pkg::dfa_slot_type head
);
   import dfa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   dfa_item_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign count_in = count_ff + CNT_W'(push.valid) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.item  = mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (count_ff < CNT_W'(DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue fill count did not advance");
`endif

endmodule

[src/dfa_back.sv]
module dfa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dfa_pkg::dfa_slot_type head,
   output logic                  pop,
   dfa_rsp_if.source             rsp_chan
);
   import dfa_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic [PRECIP_W-1:0]      precip;
      logic [COND_W-1:0]        condition;
      logic [DIST_W-1:0]        best;
   } dfa_acc_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic [PRECIP_W-1:0]      precip;
      logic [COND_W-1:0]        condition;
   } dfa_sum_type;

   localparam dfa_acc_type ACC_CLEAR = '{
      valid: 1'b0, min_temp: '0, max_temp: '0, precip: '0, condition: '0,
      best: DIST_SENTINEL
   };

   // results still to send for the captured run
   localparam logic [1:0] CNT_IDLE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   dfa_acc_type  acc_ff [2];
   dfa_acc_type  acc_in [2];
   dfa_acc_type  upd    [2];
   dfa_sum_type  sum_ff [2];
   dfa_sum_type  sum_in [2];
   logic         any_ff, any_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         out_free, take_last, out_xfer, sel;

   assign out_xfer  = rsp_chan.valid && rsp_chan.ready;
   assign out_free  = (cnt_ff == CNT_IDLE) || ((cnt_ff == CNT_ONE) && rsp_chan.ready);
   assign pop       = head.valid && (!head.item.pay.last || out_free);
   assign take_last = pop && head.item.pay.last;

   // fold the head point into both days
   always_comb begin
      logic hit;
      logic v;
      for (int d = 0; d < 2; d++) begin
         hit    = (d == 0) ? head.item.hit_today : head.item.hit_tomorrow;
         upd[d] = acc_ff[d];
         if (hit) begin
            upd[d].valid = 1'b1;
            if (!acc_ff[d].valid ||
                ($signed(head.item.pay.min_temp) < $signed(acc_ff[d].min_temp))) begin
               upd[d].min_temp = head.item.pay.min_temp;
            end
            if (!acc_ff[d].valid ||
                ($signed(head.item.pay.max_temp) > $signed(acc_ff[d].max_temp))) begin
               upd[d].max_temp = head.item.pay.max_temp;
            end
            if (head.item.pay.precip > acc_ff[d].precip) begin
               upd[d].precip = head.item.pay.precip;
            end
            if (head.item.noon_gap < acc_ff[d].best) begin
               upd[d].best      = head.item.noon_gap;
               upd[d].condition = head.item.pay.condition;
            end
         end

         v = head.item.pay.known && upd[d].valid;
         sum_in[d].valid     = v;
         sum_in[d].min_temp  = v ? upd[d].min_temp  : '0;
         sum_in[d].max_temp  = v ? upd[d].max_temp  : '0;
         sum_in[d].precip    = v ? upd[d].precip    : '0;
         sum_in[d].condition = v ? upd[d].condition : '0;

         if (take_last) begin
            acc_in[d] = ACC_CLEAR;
         end else if (pop) begin
            acc_in[d] = upd[d];
         end else begin
            acc_in[d] = acc_ff[d];
         end
      end
      any_in = head.item.pay.known && (upd[0].valid || upd[1].valid);
   end

   always_comb begin
      priority if (take_last) begin
         cnt_in = CNT_TWO;
      end else if (out_xfer) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= ACC_CLEAR;
         acc_ff[1] <= ACC_CLEAR;
         cnt_ff    <= CNT_IDLE;
      end else begin
         acc_ff[0] <= acc_in[0];
         acc_ff[1] <= acc_in[1];
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         sum_ff[0] <= sum_in[0];
         sum_ff[1] <= sum_in[1];
         any_ff    <= any_in;
      end
   end

   assign sel = (cnt_ff == CNT_ONE) ? DAY_TOMORROW : DAY_TODAY;

   assign rsp_chan.valid         = cnt_ff != CNT_IDLE;
   assign rsp_chan.day_select    = sel;
   assign rsp_chan.day_valid     = sum_ff[sel].valid;
   assign rsp_chan.day_min_temp  = sum_ff[sel].min_temp;
   assign rsp_chan.day_max_temp  = sum_ff[sel].max_temp;
   assign rsp_chan.day_precip    = sum_ff[sel].precip;
   assign rsp_chan.day_condition = sum_ff[sel].condition;
   assign rsp_chan.any_valid     = any_ff;
   assign rsp_chan.run_last      = sel;

`ifndef SYNTHESIS
   a_run_loads_pair: assert property (@(posedge clock) disable iff (reset)
      take_last |=> cnt_ff == CNT_TWO)
      else $error("last point did not load two results");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (!acc_ff[0].valid && !acc_ff[1].valid))
      else $error("accumulators not cleared after last point");

   a_day_implies_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.day_valid) |-> rsp_chan.any_valid)
      else $error("valid day reported without any_valid");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("point taken from empty queue");
`endif

endmodule

[src/daily_forecast_aggregator.sv]
// Channel    Dir  Payload                                       Transfer
// req_chan   in   point_epoch, temps, precip, condition, last   valid & ready
// rsp_chan   out  day summary, any_valid, run_last              valid & ready
// csr_*      in   csr_index, csr_wdata                          csr_wr_en
//
// One point is accepted per cycle while req_chan.ready is high. A point passes three
// front stages (local time add, reciprocal multiply for the day number, remainder and
// day match), then the queue write, before it is folded into the accumulators. A last
// point yields two results, today then tomorrow, one per cycle while rsp_chan.ready is
// high; that output register sets the rate only for runs of back-to-back last points.
// req_chan.ready drops once QUEUE_DEPTH points sit in the front and the queue.
// Synchronous active-high reset clears configuration, counters and accumulators.
module daily_forecast_aggregator #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   dfa_req_if.sink                            req_chan,
   dfa_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [dfa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dfa_pkg::*;

   // configuration registers
   logic [EPOCH_W-1:0]         cur_epoch_ff;
   logic signed [OFFSET_W-1:0] tz_offset_ff;

   // front to queue, queue to back
   dfa_slot_type push;
   dfa_slot_type head;
   logic         pop;

   // Write registers; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_epoch_ff <= '0;
         tz_offset_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CURRENT_EPOCH: begin
               cur_epoch_ff <= csr_wdata[EPOCH_W-1:0];
            end
            CSR_TIMEZONE_OFFSET: begin
               tz_offset_ff <= csr_wdata[OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Classify each point: day number, today or tomorrow, noon distance
   dfa_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cur_epoch (cur_epoch_ff),
      .tz_offset (tz_offset_ff),
      .pop       (pop),
      .push      (push)
   );

   // Hold classified points until the back end takes them
   dfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   // Accumulate per day and emit the pair of summaries on the last point
   dfa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[test/tb_daily_forecast_aggregator.sv]
module tb_daily_forecast_aggregator;
   timeunit 1ns;
   timeprecision 1ps;

   import dfa_pkg::*;

   // Day arithmetic of the forecast scheme
   localparam longint SECS_PER_DAY = 86400;
   localparam longint NOON_OFFSET  = 43200;

   // Midnight UTC of an arbitrary day, used to place directed points
   localparam logic [31:0] DAY0 = 32'd1699920000;

   // Register indexes that the block must ignore
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Cycles to let points without results drain from the front pipeline
   // and the point queue before a register write
   localparam int DRAIN_CYCLES  = 24;
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_POINTS = 1000;

   typedef struct packed {
      logic [31:0]        epoch;
      logic signed [15:0] min_temp;
      logic signed [15:0] max_temp;
      logic [6:0]         precip;
      logic [9:0]         condition;
      logic               last;
   } forecast_point_type;

   typedef struct {
      logic               sel;
      logic               valid;
      logic signed [15:0] min_temp;
      logic signed [15:0] max_temp;
      logic [6:0]         precip;
      logic [9:0]         condition;
      logic               any_day;
      logic               run_end;
   } day_summary_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dfa_req_if req_chan ();
   dfa_rsp_if rsp_chan ();

   daily_forecast_aggregator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Testbench copy of the registers and the two day tallies
   logic [31:0]        now_epoch;
   int                 tz_offset;
   logic               tally_valid [2];
   logic signed [15:0] tally_min   [2];
   logic signed [15:0] tally_max   [2];
   logic [6:0]         tally_precip[2];
   logic [9:0]         tally_cond  [2];
   logic [15:0]        tally_gap   [2];

   // Day summaries still owed by the block, oldest first
   day_summary_type pending_summaries[$];

   bit steady = 1'b0;   // set: neither side idles
   int failures       = 0;
   int points_sent    = 0;
   int random_points  = 0;
   int runs_closed    = 0;
   int csr_writes     = 0;
   int summaries_seen = 0;
   int valid_days     = 0;
   int quiet_cycles   = 0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   task automatic clear_tallies();
      for (int d = 0; d < 2; d++) begin
         tally_valid[d]  = 1'b0;
         tally_min[d]    = '0;
         tally_max[d]    = '0;
         tally_precip[d] = '0;
         tally_cond[d]   = '0;
         tally_gap[d]    = DIST_SENTINEL;
      end
   endtask

   // Floor division of a local time by one day; sec gets the time of day.
   function automatic longint floor_day(input longint local_t, output longint sec);
      longint q;
      longint r;
      q = local_t / SECS_PER_DAY;
      r = local_t % SECS_PER_DAY;
      if (r < 0) begin
         q = q - 1;
         r = r + SECS_PER_DAY;
      end
      sec = r;
      return q;
   endfunction

   task automatic merge_into_day(input int d, input forecast_point_type p,
                                 input logic [15:0] gap);
      if (!tally_valid[d]) begin
         tally_valid[d] = 1'b1;
         tally_min[d]   = p.min_temp;
         tally_max[d]   = p.max_temp;
      end else begin
         if (p.min_temp < tally_min[d]) tally_min[d] = p.min_temp;
         if (p.max_temp > tally_max[d]) tally_max[d] = p.max_temp;
      end
      if (p.precip > tally_precip[d]) tally_precip[d] = p.precip;
      // strict compare: on a tie the point seen first keeps the condition
      if (gap < tally_gap[d]) begin
         tally_gap[d]  = gap;
         tally_cond[d] = p.condition;
      end
   endtask

   // Fold one transferred point into the tallies; on the last point of a
   // run queue the today and tomorrow summaries and start over.
   task automatic fold_point(input forecast_point_type p);
      longint          pday;
      longint          cday;
      longint          psec;
      longint          csec;
      logic [15:0]     gap;
      logic            known;
      logic            v;
      day_summary_type s;
      pday = floor_day(longint'(p.epoch) + longint'(tz_offset), psec);
      cday = floor_day(longint'(now_epoch) + longint'(tz_offset), csec);
      gap  = 16'((psec >= NOON_OFFSET) ? psec - NOON_OFFSET : NOON_OFFSET - psec);
      if (pday == cday && p.epoch >= now_epoch) merge_into_day(0, p, gap);
      if (pday == cday + 1) merge_into_day(1, p, gap);
      if (p.last) begin
         known = (now_epoch != 0);
         for (int d = 0; d < 2; d++) begin
            v           = known && tally_valid[d];
            s.sel       = (d == 0) ? DAY_TODAY : DAY_TOMORROW;
            s.valid     = v;
            s.min_temp  = v ? tally_min[d] : '0;
            s.max_temp  = v ? tally_max[d] : '0;
            s.precip    = v ? tally_precip[d] : '0;
            s.condition = v ? tally_cond[d] : '0;
            s.any_day   = known && (tally_valid[0] || tally_valid[1]);
            s.run_end   = (d == 1);
            pending_summaries.push_back(s);
         end
         clear_tallies();
         runs_closed++;
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   initial begin
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.point_epoch     = '0;
      req_chan.point_min_temp  = '0;
      req_chan.point_max_temp  = '0;
      req_chan.point_precip    = '0;
      req_chan.point_condition = '0;
      req_chan.last_point      = 1'b0;
      rsp_chan.ready           = 1'b0;
      now_epoch                = '0;
      tz_offset                = 0;
      clear_tallies();
   end

   // Summary side: drop ready at random, with a probability of 31 in 100, unless steady
   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 31);
   end

   // Write one register; mirror it in the prediction. Spare indexes
   // leave the registers as they are.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CURRENT_EPOCH:   now_epoch = data;
         CSR_TIMEZONE_OFFSET: tz_offset = int'(signed'(data[16:0]));
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Transfer one point, idling first at random, and predict its effect.
   // Valid stays high after the transfer until the next caller decides.
   task automatic send_point(input forecast_point_type p);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 31) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.point_epoch     <= p.epoch;
      req_chan.point_min_temp  <= p.min_temp;
      req_chan.point_max_temp  <= p.max_temp;
      req_chan.point_precip    <= p.precip;
      req_chan.point_condition <= p.condition;
      req_chan.last_point      <= p.last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      fold_point(p);
      points_sent++;
   endtask

   // Drop valid, wait for every owed summary, then let points that
   // produce nothing leave the pipeline.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_summaries.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic forecast_point_type make_point(input logic [31:0] e, input int tmin,
                                                     input int tmax, input int pr,
                                                     input int cond, input bit last);
      forecast_point_type p;
      p.epoch     = e;
      p.min_temp  = 16'(tmin);
      p.max_temp  = 16'(tmax);
      p.precip    = 7'(pr);
      p.condition = 10'(cond);
      p.last      = last;
      return p;
   endfunction

   // Mostly points around the present time, so today and tomorrow fill up;
   // the rest anywhere in the epoch range.
   function automatic forecast_point_type rand_point(input bit last);
      forecast_point_type p;
      longint             off;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         p.epoch = now_epoch;
      end else if (pick < 10) begin
         p.epoch = now_epoch - 32'd1;
      end else if (pick < 85) begin
         off     = longint'($urandom_range(0, 4 * 86400)) - 129600;
         p.epoch = 32'(longint'(now_epoch) + off);
      end else begin
         p.epoch = $urandom();
      end
      if ($urandom_range(9) < 7) begin
         p.min_temp = 16'($urandom_range(0, 850) - 400);
         p.max_temp = 16'($urandom_range(0, 850) - 400);
      end else begin
         p.min_temp = 16'($urandom());
         p.max_temp = 16'($urandom());
      end
      p.precip    = ($urandom_range(9) == 0) ? 7'($urandom_range(101, 127))
                                             : 7'($urandom_range(0, 100));
      p.condition = 10'($urandom_range(0, 1023));
      p.last      = last;
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Summary checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each summary transfer with the oldest owed summary
   always @(posedge clock) begin : check_summary
      day_summary_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         summaries_seen++;
         if (pending_summaries.size() == 0) begin
            $error("day summary transferred with none owed");
            failures++;
         end else begin
            want = pending_summaries.pop_front();
            if (want.valid) valid_days++;
            check_field("day_select",    want.sel,       rsp_chan.day_select);
            check_field("day_valid",     want.valid,     rsp_chan.day_valid);
            check_field("day_min_temp",  want.min_temp,  rsp_chan.day_min_temp);
            check_field("day_max_temp",  want.max_temp,  rsp_chan.day_max_temp);
            check_field("day_precip",    want.precip,    rsp_chan.day_precip);
            check_field("day_condition", want.condition, rsp_chan.day_condition);
            check_field("any_valid",     want.any_day,   rsp_chan.any_valid);
            check_field("run_last",      want.run_end,   rsp_chan.run_last);
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers at reset: present time unknown, so both summaries come out
   // invalid even though the points land on today and tomorrow.
   task automatic test_unknown_time();
      send_point(make_point(32'd100, -5, 20, 30, 7, 1'b0));
      send_point(make_point(32'd129600, 10, 40, 60, 9, 1'b1));
   endtask

   // Present time at 08:20 UTC: drop the past part of today, the day after
   // tomorrow and yesterday; keep the rest of today and all of tomorrow.
   task automatic test_day_split();
      settle();
      csr_write(CSR_CURRENT_EPOCH, DAY0 + 32'd30000);
      csr_write(CSR_TIMEZONE_OFFSET, 32'd0);
      send_point(make_point(DAY0 + 32'd1000, -300, -200, 90, 1, 1'b0));
      send_point(make_point(DAY0 + 32'd30000, 50, 120, 10, 2, 1'b0));
      send_point(make_point(DAY0 + 32'd43200, 40, 150, 0, 3, 1'b0));
      send_point(make_point(DAY0 + 32'd126400, -20, 80, 40, 4, 1'b0));
      send_point(make_point(DAY0 + 32'd216000, -900, 900, 99, 5, 1'b0));
      send_point(make_point(DAY0 - 32'd100, -800, 800, 98, 6, 1'b0));
      send_point(make_point(DAY0 + 32'd129600, -10, 60, 20, 7, 1'b1));
   endtask

   // Write junk to the spare indexes; the present time and offset must hold.
   task automatic test_ignored_registers();
      settle();
      csr_write(CSR_SPARE_A, 32'hFFFF_FFFF);
      csr_write(CSR_SPARE_B, 32'h5A5A_5A5A);
      send_point(make_point(DAY0 + 32'd50000, 11, 22, 33, 44, 1'b1));
   endtask

   // Negative offset; two points equally far from local noon on each day.
   task automatic test_noon_tie();
      settle();
      csr_write(CSR_CURRENT_EPOCH, DAY0 + 32'd30000);
      csr_write(CSR_TIMEZONE_OFFSET, 32'(-18000));
      send_point(make_point(DAY0 + 32'd61300, 0, 10, 5, 11, 1'b0));
      send_point(make_point(DAY0 + 32'd61100, 1, 9, 6, 22, 1'b0));
      send_point(make_point(DAY0 + 32'd148100, 2, 8, 7, 33, 1'b0));
      send_point(make_point(DAY0 + 32'd147100, 3, 7, 8, 44, 1'b1));
   endtask

   // Extremes: last epoch second with the largest offset, then epoch 1 with
   // the most negative offset so local times go below zero. Temperatures,
   // precipitation and condition at their limits.
   task automatic test_field_extremes();
      settle();
      csr_write(CSR_CURRENT_EPOCH, 32'hFFFF_FFFF);
      csr_write(CSR_TIMEZONE_OFFSET, 32'h0000_FFFF);
      send_point(make_point(32'hFFFF_FFFF, -32768, 32767, 127, 1023, 1'b0));
      send_point(make_point(32'hFFFF_FFFE, 32767, -32768, 0, 0, 1'b0));
      send_point(make_point(32'd0, 0, 0, 100, 512, 1'b1));
      settle();
      csr_write(CSR_CURRENT_EPOCH, 32'd1);
      csr_write(CSR_TIMEZONE_OFFSET, 32'hFFFF_0000);
      send_point(make_point(32'd0, 0, 0, 100, 512, 1'b0));
      send_point(make_point(32'd5, -1, 1, 127, 1, 1'b0));
      send_point(make_point(32'd70000, -32768, 32767, 127, 1023, 1'b1));
   endtask

   // Last points back to back: nothing matches, tomorrow only, today only.
   task automatic test_back_to_back_runs();
      settle();
      csr_write(CSR_CURRENT_EPOCH, DAY0 + 32'd30000);
      csr_write(CSR_TIMEZONE_OFFSET, 32'd0);
      steady = 1'b1;
      send_point(make_point(32'd0, 5, 5, 5, 5, 1'b1));
      send_point(make_point(DAY0 + 32'd86500, -50, 50, 12, 13, 1'b1));
      send_point(make_point(DAY0 + 32'd86399, -60, 60, 14, 15, 1'b1));
      settle();
      steady = 1'b0;
   endtask

   // Phases of random runs, each under a fresh register setting. Some phases
   // end in the middle of a run, so a setting changes under open tallies.
   task automatic test_random_runs();
      int  phase;
      int  runs;
      int  len;
      int  pick;
      int  tz_pick;
      bit  open_run;
      phase = 0;
      while (random_points < RANDOM_POINTS) begin
         settle();
         steady = (phase >= 8 && phase < 14);
         pick = $urandom_range(9);
         case (pick)
            0:       csr_write(CSR_CURRENT_EPOCH, 32'd0);
            1:       csr_write(CSR_CURRENT_EPOCH, 32'hFFFF_FFFF);
            2:       csr_write(CSR_CURRENT_EPOCH, 32'($urandom_range(1, 200000)));
            default: csr_write(CSR_CURRENT_EPOCH, $urandom());
         endcase
         if ($urandom_range(9) < 7) begin
            pick = $urandom_range(9);
            case (pick)
               0:       tz_pick = -50400;
               1:       tz_pick = 50400;
               2:       tz_pick = -65536;
               3:       tz_pick = 65535;
               4:       tz_pick = 0;
               default: tz_pick = $urandom_range(0, 100800) - 50400;
            endcase
            // junk above bit 16 must not matter
            csr_write(CSR_TIMEZONE_OFFSET, {15'($urandom()), 17'(tz_pick)});
         end
         if ($urandom_range(9) == 0)
            csr_write(($urandom_range(1) == 0) ? CSR_SPARE_A : CSR_SPARE_B, $urandom());
         runs = $urandom_range(3, 8);
         for (int r = 0; r < runs; r++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
            open_run = (r == runs - 1) && ($urandom_range(3) == 0);
            for (int k = 0; k < len; k++) begin
               send_point(rand_point((k == len - 1) && !open_run));
               random_points++;
            end
         end
         phase++;
      end
      // close a run the last phase may have left open
      send_point(rand_point(1'b1));
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unknown_time();
      test_day_split();
      test_ignored_registers();
      test_noon_tie();
      test_field_extremes();
      test_back_to_back_runs();
      test_random_runs();

      // drain every owed summary, then watch a while for strays
      settle();
      if (pending_summaries.size() != 0) begin
         $error("%0d day summaries never arrived", pending_summaries.size());
         failures++;
      end

      $display("sent %0d forecast points in %0d runs across %0d register writes",
               points_sent, runs_closed, csr_writes);
      $display("checked %0d day summaries, %0d of them with a valid day",
               summaries_seen, valid_days);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
